FILE: hdl/tdbs_pkg.sv
// Shared types, constants and the 5x7 font table for the text to display byte stream block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tdbs_pkg;

  // glyph columns per character, font table entries and default queue depth
  localparam int GLYPH_COLS = 5;
  localparam int FONT_ENTRIES = 95;
  localparam int QUEUE_DEPTH_DEF = 4;

  // character range covered by the font
  localparam logic [7:0] CHAR_LO = 8'h20;
  localparam logic [7:0] CHAR_HI = 8'h7E;
  localparam logic [7:0] CHAR_END = 8'h00;
  localparam logic [6:0] SPACE_IDX = 7'd0;
  localparam logic [6:0] HASH_IDX = 7'd3;

  // bus bytes
  localparam logic [7:0] CTRL_CMD = 8'h00;
  localparam logic [7:0] CTRL_DATA = 8'h40;
  localparam logic [7:0] CMD_PAGE = 8'hB0;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] CHAR_ADVANCE = 8'd6;

  // one draw job: glyph at page / column, last marks the final job of an input beat
  typedef struct packed {
    logic [6:0] glyph;
    logic [2:0] page;
    logic [7:0] column;
    logic       last;
  } job_t;

  // byte sequencer steps of one drawn character
  typedef enum logic [3:0] {
    ST_PG_CTRL,
    ST_PG_CMD,
    ST_CL_CTRL,
    ST_CL_CMD,
    ST_CH_CTRL,
    ST_CH_CMD,
    ST_DATA_CTRL,
    ST_COL0,
    ST_COL1,
    ST_COL2,
    ST_COL3,
    ST_COL4
  } step_t;

  // font rows, column 0 in the top byte
  localparam logic [39:0] FONT_ROM [FONT_ENTRIES] = '{
    40'h0000000000, 40'h00004F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0102040000, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h064949493F,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C0418047C, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h0201020402
  };

  // font row for a glyph index, zero for indexes past the table
  function automatic logic [39:0] font_row(input logic [6:0] idx);
    logic [39:0] row;
    row = '0;
    if (idx < 7'(FONT_ENTRIES)) begin
      row = FONT_ROM[idx];
    end
    return row;
  endfunction

  // glyph index of a character code, hash for codes outside the font
  function automatic logic [6:0] glyph_index(input logic [7:0] code);
    logic [7:0] diff;
    diff = code - CHAR_LO;
    if (code < CHAR_LO || code > CHAR_HI) begin
      return HASH_IDX;
    end
    return diff[6:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tdbs_queue.sv
// Short job queue between the front and back parts of the character generator.
// Depends on tdbs_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module tdbs_queue
  import tdbs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  output logic      full,
  input  wire logic rd_en,
  output job_t      rd_job,
  output logic      rd_vld
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full   = (cnt_r == CW'(DEPTH));
  assign rd_vld = (cnt_r != '0);
  assign rd_job = mem_r[rp_r];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && rd_vld;

  // pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_job;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tdbs_front.sv
// Front part: accepts character beats, keeps the string position and queues draw jobs.
// Depends on tdbs_pkg for job_t and the glyph lookup.
`timescale 1ns / 1ps
`default_nettype none

module tdbs_front
  import tdbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // char_code[7:0], page[10:8], start_column[18:11]
  input  wire logic        in_tuser,   // first_of_string
  output logic             q_wr,
  output job_t             q_job,
  input  wire logic        q_full
);

  logic [2:0] page_r, page_nxt;
  logic [7:0] col_r, col_nxt;
  logic       open_r, open_nxt;
  logic       pend_vld_r, pend_vld_nxt;
  job_t       pend_job_r, pend_job_nxt;

  logic [7:0] code;
  logic [2:0] pg;
  logic [7:0] scol;
  logic       acc;
  logic       draw;

  assign code = in_tdata[7:0];
  assign pg   = in_tdata[10:8];
  assign scol = in_tdata[18:11];

  // a held second job of a first character blocks new beats
  assign in_tready = !pend_vld_r && !q_full;
  assign acc       = in_tvalid && in_tready;
  assign draw      = open_r && (code != CHAR_END);

  // classify the beat and pick the job to queue
  always_comb begin
    q_wr         = 1'b0;
    q_job        = pend_job_r;
    page_nxt     = page_r;
    col_nxt      = col_r;
    open_nxt     = open_r;
    pend_vld_nxt = pend_vld_r;
    pend_job_nxt = pend_job_r;
    if (pend_vld_r) begin
      q_wr = !q_full;
      if (!q_full) begin
        pend_vld_nxt = 1'b0;
      end
    end else if (acc) begin
      if (in_tuser) begin
        // space glyph first, the character itself from the pending register once the queue has room
        q_wr         = 1'b1;
        q_job        = '{glyph: SPACE_IDX, page: pg, column: scol, last: 1'b0};
        pend_vld_nxt = 1'b1;
        pend_job_nxt = '{glyph: glyph_index(code), page: pg, column: scol, last: 1'b1};
        page_nxt     = pg;
        col_nxt      = scol + CHAR_ADVANCE;
        open_nxt     = 1'b1;
      end else if (draw) begin
        q_wr    = 1'b1;
        q_job   = '{glyph: glyph_index(code), page: page_r, column: col_r, last: 1'b1};
        col_nxt = col_r + CHAR_ADVANCE;
      end else if (open_r) begin
        // zero code closes the string
        open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r     <= '0;
      col_r      <= '0;
      open_r     <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      page_r     <= page_nxt;
      col_r      <= col_nxt;
      open_r     <= open_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_job_r <= pend_job_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/tdbs_back.sv
// Back part: turns each queued draw job into twelve bus bytes through an output register.
// Depends on tdbs_pkg for job_t, step_t and the font table.
`timescale 1ns / 1ps
`default_nettype none

module tdbs_back
  import tdbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire job_t       q_job,
  input  wire logic       q_vld,
  output logic            q_rd,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // out_byte
  output logic [1:0]      out_tuser,   // frame_start, frame_end
  output logic            out_tlast    // last
);

  step_t      step_r, step_nxt;
  logic       busy_r, busy_nxt;
  job_t       job_r;
  logic       out_vld_r;
  logic [7:0] byte_r;
  logic       fs_r, fe_r, last_r;

  logic       adv;
  logic       done;
  logic [7:0] byte_c;
  logic       fs_c, fe_c, last_c;
  logic [39:0] row;

  assign adv  = !out_vld_r || out_tready;
  assign done = busy_r && (step_r == ST_COL4);
  assign q_rd = adv && (!busy_r || done) && q_vld;
  assign row  = font_row(job_r.glyph);

  // next step and busy flag
  always_comb begin
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (adv && busy_r) begin
      if (done) begin
        step_nxt = ST_PG_CTRL;
      end else begin
        step_nxt = step_t'(step_r + 4'd1);
      end
    end
    if (q_rd) begin
      busy_nxt = 1'b1;
    end else if (adv && done) begin
      busy_nxt = 1'b0;
    end
  end

  // byte of the current step
  always_comb begin
    byte_c = CTRL_CMD;
    fs_c   = 1'b0;
    fe_c   = 1'b0;
    last_c = 1'b0;
    case (step_r)
      ST_PG_CTRL, ST_CL_CTRL, ST_CH_CTRL: begin
        byte_c = CTRL_CMD;
        fs_c   = 1'b1;
      end
      ST_PG_CMD: begin
        byte_c = CMD_PAGE | {5'd0, job_r.page};
        fe_c   = 1'b1;
      end
      ST_CL_CMD: begin
        byte_c = {4'd0, job_r.column[3:0]};
        fe_c   = 1'b1;
      end
      ST_CH_CMD: begin
        byte_c = CMD_COL_HI + {4'd0, job_r.column[7:4]};
        fe_c   = 1'b1;
      end
      ST_DATA_CTRL: begin
        byte_c = CTRL_DATA;
        fs_c   = 1'b1;
      end
      ST_COL0: byte_c = row[39:32];
      ST_COL1: byte_c = row[31:24];
      ST_COL2: byte_c = row[23:16];
      ST_COL3: byte_c = row[15:8];
      ST_COL4: begin
        byte_c = row[7:0];
        fe_c   = 1'b1;
        last_c = job_r.last;
      end
      default: begin
        byte_c = CTRL_CMD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= ST_PG_CTRL;
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      if (adv) begin
        out_vld_r <= busy_r;
      end
    end
  end

  // job and output payload registers
  always_ff @(posedge clk) begin
    if (q_rd) begin
      job_r <= q_job;
    end
    if (adv) begin
      byte_r <= byte_c;
      fs_r   <= fs_c;
      fe_r   <= fe_c;
      last_r <= last_c;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = {fe_r, fs_r};
  assign out_tlast  = last_r;

  // a character's final byte always closes a frame
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[1])
    else $error("last byte without frame end");

  // a byte never both opens and closes a frame
  a_frame_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("frame start and end on one byte");

  // a new job is taken only at the start or end of a character
  a_pop_point: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> (!busy_r || step_r == ST_COL4))
    else $error("job taken mid character");

  // the step after the last glyph column is a page control byte
  a_step_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    adv && done |=> step_r == ST_PG_CTRL)
    else $error("sequencer did not wrap");

endmodule

`default_nettype wire

FILE: hdl/text_to_display_byte_stream_core.sv
// Character generator core: character beats in, display controller bus bytes out.
// Instantiates tdbs_front, tdbs_queue and tdbs_back; uses tdbs_pkg.
//
// Every accepted character inside an open string gives twelve output beats: three command
// frames (page, column low nibble, column high nibble) and one data frame of five 5x7 glyph
// columns. A beat with first_of_string set opens a string and gives twenty-four beats, a
// space glyph and then the character, both at start_column. A zero code in an open string
// closes it and gives nothing, as does any beat while no string is open. The back sequencer
// emits one byte per cycle while out_tready is high and a draw job is in hand; the front
// keeps taking beats while fewer than QUEUE_DEPTH draw jobs wait in the queue.
`timescale 1ns / 1ps
`default_nettype none

module text_to_display_byte_stream_core
  import tdbs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // char_code[7:0], page[10:8], start_column[18:11]
  input  wire logic        in_tuser,   // first_of_string
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // out_byte[7:0]
  output logic [1:0]       out_tuser,  // frame_start[0], frame_end[1]
  output logic             out_tlast   // last
);

  logic q_wr, q_full, q_rd, q_vld;
  job_t q_wr_job, q_rd_job;

  // beat intake and string state
  tdbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_wr      (q_wr),
    .q_job     (q_wr_job),
    .q_full    (q_full)
  );

  // draw job queue
  tdbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_wr),
    .wr_job (q_wr_job),
    .full   (q_full),
    .rd_en  (q_rd),
    .rd_job (q_rd_job),
    .rd_vld (q_vld)
  );

  // byte sequencer
  tdbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_job      (q_rd_job),
    .q_vld      (q_vld),
    .q_rd       (q_rd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
